@@ src/hpf_pkg.sv @@
// Package for the handshake packet framer.
// Command format between front and back, back sequencer states, register map
// and fixed byte values. No dependencies.
package hpf_pkg;

  // Default clamp on the address length
  localparam int DefMaxAddressBytes = 255;

  // Command queue depth (power of two)
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // APB register map (word index = paddr[3:2])
  localparam int PaddrW = 4;
  localparam logic [1:0] REG_PROTOCOL_VERSION = 2'd0;
  localparam logic [1:0] REG_SERVER_PORT      = 2'd1;
  localparam logic [1:0] REG_APPEND_STATUS    = 2'd2;

  localparam logic [31:0] PROTOCOL_VERSION_RST = 32'd754;

  // Fixed packet bytes
  localparam logic [7:0] PACKET_ID_BYTE   = 8'h00;
  localparam logic [7:0] NEXT_STATE_BYTE  = 8'h01;
  localparam logic [7:0] STATUS_ID_BYTE   = 8'h01;
  localparam logic [7:0] STATUS_TAIL_BYTE = 8'h00;

  typedef enum logic {
    CMD_HEADER,
    CMD_ADDR
  } cmd_kind_e;

  // header: data = address length, payload = varint length prefix value
  // addr:   data = address byte
  // trailer set when the port/next-state trailer follows this command
  typedef struct packed {
    cmd_kind_e   kind;
    logic        trailer;
    logic [7:0]  data;
    logic [8:0]  payload;
  } hpf_cmd_t;

  typedef enum logic [3:0] {
    B_FETCH,
    B_PAYLEN,
    B_ID,
    B_VER,
    B_ALEN,
    B_PORT_HI,
    B_PORT_LO,
    B_NSTATE,
    B_STAT1,
    B_STAT0
  } back_state_e;

endpackage

@@ src/handshake_packet_framer.sv @@
// Handshake packet framer top level: APB register block, front end, command
// queue and byte sequencer. Uses hpf_pkg, hpf_front, hpf_cmd_fifo, hpf_back.
//
// Turns a stream of requests (a first request carrying the address length,
// then one request per address byte) into a length-prefixed handshake packet,
// one byte per output request. Address bytes pass at one per cycle unless
// stalled. A first request expands into a fetch step plus 4 to 10 header bytes,
// and the last address byte (or an empty-address first request) adds a 3-byte
// trailer, 5 bytes with the status request appended. The back sequencer emits
// one byte per cycle unless stalled and sets the rate; a 4-entry command queue
// lets the input keep accepting while a burst drains. Address requests with no
// open packet are dropped. Write registers only while the block is idle.
module handshake_packet_framer
  import hpf_pkg::*;
#(
  parameter int MAX_ADDRESS_BYTES = DefMaxAddressBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              first_of_packet_i,
  input  logic [7:0]        address_length_i,
  input  logic [7:0]        address_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        packet_byte_o,
  output logic              last_of_run_o,
  output logic              end_of_packet_o
);

  logic [31:0] protocol_version_q;
  logic [15:0] server_port_q;
  logic        append_status_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  logic     push, full, pop, empty;
  hpf_cmd_t push_cmd, head_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protocol_version_q <= PROTOCOL_VERSION_RST;
      server_port_q      <= 16'd0;
      append_status_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PROTOCOL_VERSION: protocol_version_q <= pwdata;
        REG_SERVER_PORT:      server_port_q      <= pwdata[15:0];
        REG_APPEND_STATUS:    append_status_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROTOCOL_VERSION: prdata = protocol_version_q;
      REG_SERVER_PORT:      prdata = {16'd0, server_port_q};
      REG_APPEND_STATUS:    prdata = {31'd0, append_status_q};
      default:              prdata = 32'd0;
    endcase
  end

  hpf_front #(
    .MAX_ADDRESS_BYTES(MAX_ADDRESS_BYTES)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .first_of_packet_i  (first_of_packet_i),
    .address_length_i   (address_length_i),
    .address_byte_i     (address_byte_i),
    .protocol_version_i (protocol_version_q),
    .queue_full_i       (full),
    .push_o             (push),
    .cmd_o              (push_cmd)
  );

  hpf_cmd_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_cmd)
  );

  hpf_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .empty_i            (empty),
    .head_i             (head_cmd),
    .pop_o              (pop),
    .protocol_version_i (protocol_version_q),
    .server_port_i      (server_port_q),
    .append_status_i    (append_status_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .packet_byte_o      (packet_byte_o),
    .last_of_run_o      (last_of_run_o),
    .end_of_packet_o    (end_of_packet_o)
  );

endmodule

@@ src/hpf_front.sv @@
// Front end of the framer: accepts input requests, tracks the open packet and
// turns each request into a header or address command. Uses hpf_pkg.
module hpf_front
  import hpf_pkg::*;
#(
  parameter int MAX_ADDRESS_BYTES = DefMaxAddressBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_of_packet_i,
  input  logic [7:0]  address_length_i,
  input  logic [7:0]  address_byte_i,
  input  logic [31:0] protocol_version_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output hpf_cmd_t    cmd_o
);

  localparam logic [7:0] MaxLen =
    (MAX_ADDRESS_BYTES > 255) ? 8'd255 : 8'(MAX_ADDRESS_BYTES);

  logic       open_q, open_d;
  logic [7:0] left_q, left_d;
  logic       accept;
  logic [7:0] len;
  logic [8:0] payload;

  function automatic logic [2:0] varint_len(input logic [31:0] v);
    logic [2:0] n;
    if (|v[31:28])      n = 3'd5;
    else if (|v[27:21]) n = 3'd4;
    else if (|v[20:14]) n = 3'd3;
    else if (|v[13:7])  n = 3'd2;
    else                n = 3'd1;
    return n;
  endfunction

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  assign len = (address_length_i > MaxLen) ? MaxLen : address_length_i;
  // id byte + version + length varint + address + port(2) + next state
  assign payload = 9'(len) + 9'(varint_len(protocol_version_i))
                 + 9'(varint_len({24'd0, len})) + 9'd4;

  always_comb begin
    open_d        = open_q;
    left_d        = left_q;
    push_o        = 1'b0;
    cmd_o.kind    = CMD_ADDR;
    cmd_o.trailer = 1'b0;
    cmd_o.data    = address_byte_i;
    cmd_o.payload = '0;
    if (first_of_packet_i) begin
      cmd_o.kind    = CMD_HEADER;
      cmd_o.data    = len;
      cmd_o.payload = payload;
      cmd_o.trailer = (len == 8'd0);
      push_o        = accept;
      if (accept) begin
        open_d = (len != 8'd0);
        left_d = len;
      end
    end else if (open_q) begin
      cmd_o.trailer = (left_q == 8'd1);
      push_o        = accept;
      if (accept) begin
        left_d = left_q - 8'd1;
        open_d = (left_q != 8'd1);
      end
    end
    // address request with no open packet is dropped
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

@@ src/hpf_cmd_fifo.sv @@
// Short command queue between front and back of the framer.
// Depth from hpf_pkg; one push and one pop per cycle.
module hpf_cmd_fifo
  import hpf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hpf_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output hpf_cmd_t head_o
);

  hpf_cmd_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_q, rd_q;
  logic [QueuePtrW:0]     cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ src/hpf_back.sv @@
// Back end of the framer: byte sequencer that expands queued commands into
// the packet byte stream, with a registered output stage. Uses hpf_pkg.
module hpf_back
  import hpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  hpf_cmd_t    head_i,
  output logic        pop_o,
  input  logic [31:0] protocol_version_i,
  input  logic [15:0] server_port_i,
  input  logic        append_status_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  packet_byte_o,
  output logic        last_of_run_o,
  output logic        end_of_packet_o
);

  back_state_e state_q, state_d;
  logic [31:0] vr_q, vr_d;
  logic [7:0]  len_q, len_d;
  logic        trl_q, trl_d;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        last_q, eop_q;

  logic        load;
  logic        emit, last, eop;
  logic [7:0]  byte_d;
  logic        vr_more;
  logic [7:0]  vr_byte;

  assign load    = !out_valid_q || !out_stall_i;
  assign vr_more = |vr_q[31:7];
  assign vr_byte = {vr_more, vr_q[6:0]};

  always_comb begin
    state_d = state_q;
    vr_d    = vr_q;
    len_d   = len_q;
    trl_d   = trl_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    byte_d  = 8'd0;
    last    = 1'b0;
    eop     = 1'b0;
    if (load) begin
      unique case (state_q)
        B_FETCH: begin
          if (!empty_i) begin
            pop_o = 1'b1;
            if (head_i.kind == CMD_HEADER) begin
              vr_d    = 32'(head_i.payload);
              len_d   = head_i.data;
              trl_d   = head_i.trailer;
              state_d = B_PAYLEN;
            end else begin
              emit   = 1'b1;
              byte_d = head_i.data;
              if (head_i.trailer) state_d = B_PORT_HI;
              else                last    = 1'b1;
            end
          end
        end
        B_PAYLEN: begin
          emit   = 1'b1;
          byte_d = vr_byte;
          vr_d   = vr_q >> 7;
          if (!vr_more) state_d = B_ID;
        end
        B_ID: begin
          emit    = 1'b1;
          byte_d  = PACKET_ID_BYTE;
          vr_d    = protocol_version_i;
          state_d = B_VER;
        end
        B_VER: begin
          emit   = 1'b1;
          byte_d = vr_byte;
          vr_d   = vr_q >> 7;
          if (!vr_more) begin
            vr_d    = 32'(len_q);
            state_d = B_ALEN;
          end
        end
        B_ALEN: begin
          emit   = 1'b1;
          byte_d = vr_byte;
          vr_d   = vr_q >> 7;
          if (!vr_more) begin
            if (trl_q) begin
              state_d = B_PORT_HI;
            end else begin
              last    = 1'b1;
              state_d = B_FETCH;
            end
          end
        end
        B_PORT_HI: begin
          emit    = 1'b1;
          byte_d  = server_port_i[15:8];
          state_d = B_PORT_LO;
        end
        B_PORT_LO: begin
          emit    = 1'b1;
          byte_d  = server_port_i[7:0];
          state_d = B_NSTATE;
        end
        B_NSTATE: begin
          emit   = 1'b1;
          byte_d = NEXT_STATE_BYTE;
          if (append_status_i) begin
            state_d = B_STAT1;
          end else begin
            last    = 1'b1;
            eop     = 1'b1;
            state_d = B_FETCH;
          end
        end
        B_STAT1: begin
          emit    = 1'b1;
          byte_d  = STATUS_ID_BYTE;
          state_d = B_STAT0;
        end
        B_STAT0: begin
          emit    = 1'b1;
          byte_d  = STATUS_TAIL_BYTE;
          last    = 1'b1;
          eop     = 1'b1;
          state_d = B_FETCH;
        end
        default: state_d = B_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_FETCH;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    vr_q  <= vr_d;
    len_q <= len_d;
    trl_q <= trl_d;
    if (load && emit) begin
      byte_q <= byte_d;
      last_q <= last;
      eop_q  <= eop;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packet_byte_o   = byte_q;
  assign last_of_run_o   = last_q;
  assign end_of_packet_o = eop_q;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for handshake_packet_framer: random and directed request
// streams, APB register setup, and a byte-exact frame predictor.
// Depends on hpf_pkg and the framer RTL only.
`timescale 1ns / 1ps

module tb;
  import hpf_pkg::*;

  localparam int MaxAddr     = DefMaxAddressBytes;
  localparam int DrainCycles = 40;
  localparam int PhaseItems  = 15;

  typedef struct {
    logic       first;
    logic [7:0] len;
    logic [7:0] data;
  } frame_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eop;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       first_of_packet_i = 1'b0;
  logic [7:0] address_length_i = '0;
  logic [7:0] address_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] packet_byte_o;
  logic       last_of_run_o;
  logic       end_of_packet_o;

  handshake_packet_framer u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .first_of_packet_i(first_of_packet_i),
    .address_length_i (address_length_i),
    .address_byte_i   (address_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .packet_byte_o    (packet_byte_o),
    .last_of_run_o    (last_of_run_o),
    .end_of_packet_o  (end_of_packet_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Register shadows and framer state
  logic [31:0] ver_reg = PROTOCOL_VERSION_RST;
  logic [15:0] port_reg = '0;
  logic        status_reg = 1'b0;
  logic [7:0]  addr_left = '0;
  logic        pkt_open = 1'b0;

  frame_byte_t expected_bytes[$];
  frame_req_t  pending_reqs[$];
  int          mismatches = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          in_taken = 1'b0;
  bit          quiet = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int varint_size(logic [31:0] v);
    int n;
    n = 1;
    while (v > 32'h7F) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    frame_byte_t fb;
    fb.data = b;
    fb.last = 1'b0;
    fb.eop = 1'b0;
    expected_bytes.push_back(fb);
  endfunction

  function automatic void push_varint(logic [31:0] v);
    while (v > 32'h7F) begin
      push_byte({1'b1, v[6:0]});
      v = v >> 7;
    end
    push_byte({1'b0, v[6:0]});
  endfunction

  function automatic void flag_tail(bit set_last, bit set_eop);
    frame_byte_t fb;
    fb = expected_bytes.pop_back();
    if (set_last) fb.last = 1'b1;
    if (set_eop) fb.eop = 1'b1;
    expected_bytes.push_back(fb);
  endfunction

  function automatic void push_trailer();
    push_byte(port_reg[15:8]);
    push_byte(port_reg[7:0]);
    push_byte(NEXT_STATE_BYTE);
    if (status_reg) begin
      push_byte(STATUS_ID_BYTE);
      push_byte(STATUS_TAIL_BYTE);
    end
    flag_tail(1'b0, 1'b1);
    pkt_open = 1'b0;
    addr_left = '0;
  endfunction

  // Expected bytes for one accepted request
  function automatic void frame_request(logic first, logic [7:0] len_f, logic [7:0] byte_f);
    int len;
    if (first) begin
      len = int'(len_f);
      if (len > MaxAddr) len = MaxAddr;
      push_varint(1 + varint_size(ver_reg) + varint_size(len) + len + 3);
      push_byte(PACKET_ID_BYTE);
      push_varint(ver_reg);
      push_varint(len);
      pkt_open = 1'b1;
      addr_left = len[7:0];
      if (addr_left == 0) push_trailer();
    end else begin
      if (!pkt_open) return;  // dropped, nothing comes out
      push_byte(byte_f);
      addr_left = addr_left - 8'd1;
      if (addr_left == 0) push_trailer();
    end
    flag_tail(1'b1, 1'b0);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: presents queued requests at the falling edge
  always @(negedge clk) begin
    frame_req_t req;
    logic       nv;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        first_of_packet_i <= req.first;
        address_length_i <= req.len;
        address_byte_i <= req.data;
        nv = 1'b1;
        gap_left = (quiet || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
      end
      in_valid_i <= nv;
    end
  end

  // Output back-pressure
  always @(negedge clk) begin
    logic ns;
    if (rst_ni) begin
      if (quiet) begin
        stall_left = 0;
        ns = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ns = out_stall_i;
      end else begin
        ns = ($urandom_range(0, 3) == 0);
        stall_left = ns ? pick_gap() : $urandom_range(0, 6);
      end
      out_stall_i <= ns;
    end
  end

  // Monitor: predicts on input handshakes, then checks output handshakes
  always @(posedge clk) begin
    frame_byte_t fb;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) frame_request(first_of_packet_i, address_length_i, address_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected packet_byte", 32'(packet_byte_o), '0);
        end else begin
          fb = expected_bytes.pop_front();
          if (packet_byte_o !== fb.data)
            report_mismatch("packet_byte", 32'(packet_byte_o), 32'(fb.data));
          if (last_of_run_o !== fb.last)
            report_mismatch("last_of_run", 32'(last_of_run_o), 32'(fb.last));
          if (end_of_packet_o !== fb.eop)
            report_mismatch("end_of_packet", 32'(end_of_packet_o), 32'(fb.eop));
        end
      end
    end
  end

  task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    apb_access(1'b0, REG_PROTOCOL_VERSION, '0, rd);
    if (rd !== ver_reg) report_mismatch("protocol_version readback", rd, ver_reg);
    apb_access(1'b0, REG_SERVER_PORT, '0, rd);
    if (rd !== {16'h0, port_reg})
      report_mismatch("server_port readback", rd, 32'(port_reg));
    apb_access(1'b0, REG_APPEND_STATUS, '0, rd);
    if (rd !== {31'h0, status_reg})
      report_mismatch("append_status readback", rd, 32'(status_reg));
  endtask

  task automatic set_config(input logic [31:0] ver, input logic [15:0] port, input logic st);
    logic [31:0] rd;
    apb_access(1'b1, REG_PROTOCOL_VERSION, ver, rd);
    ver_reg = ver;
    apb_access(1'b1, REG_SERVER_PORT, {16'h0, port}, rd);
    port_reg = port;
    apb_access(1'b1, REG_APPEND_STATUS, {31'h0, st}, rd);
    status_reg = st;
    check_regs();
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic void add_req(logic first, logic [7:0] len, logic [7:0] data);
    frame_req_t req;
    req.first = first;
    req.len = len;
    req.data = data;
    pending_reqs.push_back(req);
  endfunction

  // Returns the number of requests queued; abandon cuts the address short
  function automatic int add_packet(int len, bit abandon);
    int n;
    n = (abandon && len > 0) ? $urandom_range(0, len - 1) : len;
    add_req(1'b1, len[7:0], 8'($urandom_range(0, 255)));
    for (int i = 0; i < n; i++)
      add_req(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    return n + 1;
  endfunction

  function automatic int random_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 4);
    if (r < 90) return $urandom_range(5, 16);
    return $urandom_range(17, 40);
  endfunction

  function automatic int fill_random(int budget);
    int cnt;
    bit cut;
    cnt = 0;
    while (cnt < budget) begin
      cut = ($urandom_range(0, 99) < 10);
      cnt += add_packet(random_len(), cut);
      // stray address requests land between packets and are dropped
      if (!cut && $urandom_range(0, 99) < 8)
        add_req(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    return cnt;
  endfunction

  initial begin
    int cnt;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    check_regs();

    // Directed: stray byte, empty address, abandoned packet, edge byte values
    add_req(1'b0, 8'hFF, 8'hFF);
    add_req(1'b1, 8'h00, 8'hFF);
    add_req(1'b1, 8'h01, 8'h00);
    add_req(1'b0, 8'h00, 8'hFF);
    add_req(1'b1, 8'h03, 8'h00);
    add_req(1'b0, 8'hFF, 8'h00);
    add_req(1'b1, 8'h02, 8'hFF);
    add_req(1'b0, 8'h00, 8'h80);
    add_req(1'b0, 8'h00, 8'h7F);
    add_req(1'b0, 8'h55, 8'h33);
    add_req(1'b1, 8'h04, 8'h00);
    add_req(1'b0, 8'h00, 8'hA5);
    add_req(1'b0, 8'hFF, 8'h5A);
    add_req(1'b0, 8'h00, 8'h01);
    add_req(1'b0, 8'hAA, 8'hFE);
    wait_idle();

    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: set_config(32'h0, 16'hFFFF, 1'b1);
        2: set_config(32'hFFFF_FFFF, 16'h0, 1'b0);
        3: set_config(32'd127, 16'h8001, 1'b1);
        4: set_config(32'd128, 16'($urandom_range(0, 65535)), 1'b0);
        default: set_config($urandom >> $urandom_range(0, 31),
                            16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      endcase
      quiet = (ph == 4);
      cnt = 0;
      if (ph == 2) cnt += add_packet(255, 1'b0);
      if (ph == 3) cnt += add_packet(128, 1'b0);
      if (ph == 3) begin
        // sender holds off until everything queued so far has come out
        cnt += fill_random(PhaseItems / 2);
        while (pending_reqs.size() != 0 || in_valid_i || expected_bytes.size() != 0)
          @(posedge clk);
      end
      cnt += fill_random(PhaseItems - cnt);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
